// ===== src/sdemit_pkg.sv =====
`default_nettype none

package sdemit_pkg;

    localparam int DATA_W             = 32;
    localparam int DIGIT_W            = 4;
    localparam int CHAR_W             = 7;
    localparam int COUNT_W            = 5;
    localparam int WORD_W             = 64;
    localparam int BUF_DEPTH          = 32;
    localparam int BUF_AW             = $clog2(BUF_DEPTH);
    localparam int LEN_W              = BUF_AW + 1;
    localparam int STEP_W             = $clog2(DATA_W);
    localparam int MAX_DIGITS_DEFAULT = 16;

    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_LOW   = 8'd33;
    localparam logic [7:0] CH_HIGH  = 8'd126;

    localparam logic [1:0] REG_DIGITS_LOW  = 2'd0;
    localparam logic [1:0] REG_DIGITS_HIGH = 2'd1;
    localparam logic [1:0] REG_DIGIT_COUNT = 2'd2;

    typedef struct packed {
        logic                 done;
        logic [DATA_W-1:0]    quotient;
        logic [DIGIT_W-1:0]   remainder;
    } div_result_t;

endpackage

`default_nettype wire

// ===== src/signed_radix_digit_emitter_top.sv =====
// channel   direction  signals                          transaction
// input     in         start, busy, value               start high while busy low
// result    out        strobe, character, last          strobe high for one cycle
// config    in         cfg_write, cfg_index, cfg_data   cfg_write high, no wait
//
// a value passes the N alphabet check steps (one character per step, checked for
// range, sign characters and repeats among the characters after it), the bit-serial
// divider once per digit, the sign state, and then per digit a buffer read and the
// output register. an invalid digit count or alphabet emits nothing. the longest
// text is a sign and 32 binary digits; busy is high from the cycle after the
// accept until the last digit leaves the buffer. reset clears the control state
// and the registers; the receiver cannot stall the result strobes.
`default_nettype none

module signed_radix_digit_emitter_top
    import sdemit_pkg::*;
#(
    parameter int MAX_DIGITS_IN_ALPHABET = MAX_DIGITS_DEFAULT
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic signed [DATA_W-1:0]   value,
    output logic                            strobe,
    output logic             [CHAR_W-1:0]   character,
    output logic                            last,
    input  wire logic                       cfg_write,
    input  wire logic        [1:0]          cfg_index,
    input  wire logic        [WORD_W-1:0]   cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_SIGN,
        S_READ,
        S_EMIT
    } state_t;

    function automatic logic [7:0] alpha_char(
        input logic [WORD_W-1:0]  lo,
        input logic [WORD_W-1:0]  hi,
        input logic [DIGIT_W-1:0] k
    );
        logic [WORD_W-1:0] word;
        word = k[DIGIT_W-1] ? hi : lo;
        return word[{k[DIGIT_W-2:0], 3'b000} +: 8];
    endfunction

    logic [WORD_W-1:0]  digits_low_reg;
    logic [WORD_W-1:0]  digits_high_reg;
    logic [COUNT_W-1:0] digit_count_reg;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] n_reg, n_next;
    logic [DIGIT_W-1:0] idx_reg, idx_next;
    logic [DATA_W-1:0]  mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [BUF_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic               div_start_reg, div_start_next;
    logic               strobe_reg, strobe_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;

    div_result_t        div_res;
    logic               buf_we;
    logic [DIGIT_W-1:0] rd_digit;
    logic [DATA_W-1:0]  value_u;
    logic [7:0]         cur_char;
    logic [7:0]         out_char;
    logic               dup;
    logic               bad_char;
    logic               count_ok;

    assign value_u  = $unsigned(value);
    assign count_ok = (n_next >= COUNT_W'(2)) &&
                      (n_next <= COUNT_W'(MAX_DIGITS_IN_ALPHABET));
    assign cur_char = alpha_char(digits_low_reg, digits_high_reg, idx_reg);
    assign out_char = alpha_char(digits_low_reg, digits_high_reg, rd_digit);

    always_comb
    begin
        dup = 1'b0;
        for (int j = 0; j < MAX_DIGITS_DEFAULT; j++)
        begin
            if ((COUNT_W'(j) > {1'b0, idx_reg}) && (COUNT_W'(j) < n_reg) &&
                (alpha_char(digits_low_reg, digits_high_reg, DIGIT_W'(j)) == cur_char))
            begin
                dup = 1'b1;
            end
        end
    end

    assign bad_char = (cur_char < CH_LOW) || (cur_char > CH_HIGH) ||
                      (cur_char == CH_PLUS) || (cur_char == CH_MINUS) || dup;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_low_reg  <= '0;
            digits_high_reg <= '0;
            digit_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DIGITS_LOW:  digits_low_reg  <= cfg_data;
                REG_DIGITS_HIGH: digits_high_reg <= cfg_data;
                REG_DIGIT_COUNT: digit_count_reg <= cfg_data[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        len_next       = len_reg;
        rd_ptr_next    = rd_ptr_reg;
        div_start_next = 1'b0;
        strobe_next    = 1'b0;
        char_next      = char_reg;
        last_next      = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                n_next = digit_count_reg;
                if (start)
                begin
                    neg_next = value_u[DATA_W-1];
                    mag_next = value_u[DATA_W-1] ? (~value_u + 1'b1) : value_u;
                    idx_next = '0;
                    if (count_ok)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (bad_char)
                begin
                    state_next = S_IDLE;
                end
                else if ({1'b0, idx_reg} == n_reg - 1'b1)
                begin
                    state_next     = S_DIV;
                    div_start_next = 1'b1;
                    len_next       = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    len_next = len_reg + 1'b1;
                    if (div_res.quotient == '0)
                    begin
                        state_next = S_SIGN;
                    end
                    else
                    begin
                        mag_next       = div_res.quotient;
                        div_start_next = 1'b1;
                    end
                end
            end
            S_SIGN:
            begin
                rd_ptr_next = BUF_AW'(len_reg - 1'b1);
                state_next  = S_READ;
                if (neg_reg)
                begin
                    strobe_next = 1'b1;
                    char_next   = CH_MINUS[CHAR_W-1:0];
                    last_next   = 1'b0;
                end
            end
            S_READ:
            begin
                // buffer read data lands in the next cycle
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                strobe_next = 1'b1;
                char_next   = out_char[CHAR_W-1:0];
                last_next   = (rd_ptr_reg == '0);
                if (rd_ptr_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_ptr_next = rd_ptr_reg - 1'b1;
                    state_next  = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            idx_reg       <= '0;
            neg_reg       <= 1'b0;
            len_reg       <= '0;
            rd_ptr_reg    <= '0;
            div_start_reg <= 1'b0;
            strobe_reg    <= 1'b0;
            last_reg      <= 1'b0;
            char_reg      <= '0;
            mag_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            neg_reg       <= neg_next;
            len_reg       <= len_next;
            rd_ptr_reg    <= rd_ptr_next;
            div_start_reg <= div_start_next;
            strobe_reg    <= strobe_next;
            last_reg      <= last_next;
            char_reg      <= char_next;
            mag_reg       <= mag_next;
        end
    end

    assign buf_we = (state_reg == S_DIV) && div_res.done;

    sdemit_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (mag_reg),
        .divisor  (n_reg),
        .result   (div_res)
    );

    sdemit_buf u_buf (
        .clk     (clk),
        .wr_en   (buf_we),
        .wr_addr (len_reg[BUF_AW-1:0]),
        .wr_data (div_res.remainder),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_digit)
    );

    assign busy      = (state_reg != S_IDLE);
    assign strobe    = strobe_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// ===== src/sdemit_div.sv =====
`default_nettype none

module sdemit_div
    import sdemit_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [DATA_W-1:0]   dividend,
    input  wire logic [COUNT_W-1:0]  divisor,
    output div_result_t              result
);

    logic [DATA_W-1:0]   quo_reg;
    logic [DIGIT_W-1:0]  rem_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                run_reg;
    logic                done_reg;

    logic [COUNT_W-1:0]  trial;
    logic                fits;
    logic [COUNT_W-1:0]  diff;

    // one restoring step per cycle, quotient bits shift in behind the dividend
    assign trial = {rem_reg, quo_reg[DATA_W-1]};
    assign fits  = (trial >= divisor);
    assign diff  = trial - divisor;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DATA_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[DATA_W-2:0], fits};
            rem_reg <= fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
        end
    end

    assign result.done      = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg;

endmodule

`default_nettype wire

// ===== src/sdemit_buf.sv =====
`default_nettype none

module sdemit_buf
    import sdemit_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                wr_en,
    input  wire logic [BUF_AW-1:0]   wr_addr,
    input  wire logic [DIGIT_W-1:0]  wr_data,
    input  wire logic [BUF_AW-1:0]   rd_addr,
    output logic      [DIGIT_W-1:0]  rd_data
);

    logic [DIGIT_W-1:0] mem [BUF_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sdemit_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam int unsigned DRAIN_PAUSE  = 1200;
    localparam int unsigned RANDOM_ITEMS = 260;
    localparam int unsigned MAX_REPORTS  = 40;

    // no register sits at this index, writes to it must be dropped
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam logic [WORD_W-1:0] HEX_LOW  = 64'h3736_3534_3332_3130;
    localparam logic [WORD_W-1:0] HEX_HIGH = 64'h4645_4443_4241_3938;

    // sender idle percentage per phase; no phase idles the receiver since
    // results cannot be held off
    localparam int unsigned IDLE_PCT [4] = '{0, 50, 0, 18};

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } text_char_t;

    typedef struct {
        bit                 is_write;
        logic [1:0]         index;
        logic [WORD_W-1:0]  data;
        logic [DATA_W-1:0]  operand;
        bit                 typed;
        string              text;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start     = 1'b0;
    logic                 busy;
    logic [DATA_W-1:0]    value     = '0;
    logic                 strobe;
    logic [CHAR_W-1:0]    character;
    logic                 last;
    logic                 cfg_write = 1'b0;
    logic [1:0]           cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data  = '0;

    // mirror of the alphabet registers
    logic [WORD_W-1:0]    alpha_low   = '0;
    logic [WORD_W-1:0]    alpha_high  = '0;
    logic [COUNT_W-1:0]   alpha_count = '0;

    text_char_t           pending_chars [$];
    stim_row_t            stim_rows [$];

    int unsigned          error_count   = 0;
    int unsigned          cycle_count   = 0;
    int unsigned          values_sent   = 0;
    int unsigned          silent_values = 0;
    int unsigned          chars_checked = 0;
    int unsigned          settings_used = 0;
    logic [16:0]          radix_seen    = '0;

    signed_radix_digit_emitter_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .strobe    (strobe),
        .character (character),
        .last      (last),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    function automatic logic [7:0] alphabet_char(input int unsigned k);
        if (k < 8)
            return alpha_low[8*k +: 8];
        return alpha_high[8*(k-8) +: 8];
    endfunction

    function automatic bit alphabet_valid();
        int unsigned i;
        int unsigned j;
        logic [7:0]  c;
        if (alpha_count < 2 || alpha_count > MAX_DIGITS_DEFAULT)
            return 1'b0;
        for (i = 0; i < alpha_count; i++)
        begin
            c = alphabet_char(i);
            if (c < CH_LOW || c > CH_HIGH || c == CH_PLUS || c == CH_MINUS)
                return 1'b0;
            for (j = i + 1; j < alpha_count; j++)
                if (alphabet_char(j) == c)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // expected text of one value under the current alphabet
    function automatic void predict_text(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] mag;
        logic [7:0]        digits [$];
        logic [7:0]        d;
        int unsigned       radix;
        text_char_t        tc;
        radix = 32'(alpha_count);
        if (!alphabet_valid())
            return;
        radix_seen[radix] = 1'b1;
        mag = v[DATA_W-1] ? -v : v;
        do
        begin
            digits.push_front(alphabet_char(mag % radix));
            mag = mag / radix;
        end
        while (mag != 0);
        if (v[DATA_W-1])
        begin
            tc.character = CH_MINUS[CHAR_W-1:0];
            tc.last      = 1'b0;
            pending_chars.push_back(tc);
        end
        while (digits.size() != 0)
        begin
            d = digits.pop_front();
            tc.character = d[CHAR_W-1:0];
            tc.last      = (digits.size() == 0);
            pending_chars.push_back(tc);
        end
    endfunction

    function automatic void push_text(input string s);
        byte        b;
        text_char_t tc;
        for (int i = 0; i < s.len(); i++)
        begin
            b = s[i];
            tc.character = b[CHAR_W-1:0];
            tc.last      = (i == s.len() - 1);
            pending_chars.push_back(tc);
        end
    endfunction

    function automatic stim_row_t cfg_row(input logic [1:0] index,
                                          input logic [WORD_W-1:0] data);
        stim_row_t r;
        r.is_write = 1'b1;
        r.index    = index;
        r.data     = data;
        r.operand  = '0;
        r.typed    = 1'b0;
        r.text     = "";
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic [DATA_W-1:0] v, input string s);
        stim_row_t r;
        r.is_write = 1'b0;
        r.index    = '0;
        r.data     = '0;
        r.operand  = v;
        r.typed    = 1'b1;
        r.text     = s;
        return r;
    endfunction

    function automatic stim_row_t predicted_row(input logic [DATA_W-1:0] v);
        stim_row_t r;
        r = typed_row(v, "");
        r.typed = 1'b0;
        return r;
    endfunction

    // leaves cfg_write high so back-to-back writes never drop it mid-step
    task automatic write_reg(input logic [1:0] index, input logic [WORD_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        case (index)
            REG_DIGITS_LOW:  alpha_low   = data;
            REG_DIGITS_HIGH: alpha_high  = data;
            REG_DIGIT_COUNT: alpha_count = data[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    // holds start until the transaction is taken, then stores its expected text
    task automatic send_value(input logic [DATA_W-1:0] v, input bit typed, input string s);
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        values_sent++;
        if (!alphabet_valid())
            silent_values++;
        if (typed)
            push_text(s);
        else
            predict_text(v);
    endtask

    task automatic sender_gap(input int unsigned pct);
        int unsigned cycles;
        if ($urandom_range(0, 99) >= pct)
            return;
        cycles = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 1200) : $urandom_range(1, 8);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // idle the block: all text in, then room for a value that emits nothing
    task automatic drain_block();
        start     <= 1'b0;
        cfg_write <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic pick_alphabet();
        logic [7:0]        chars [16];
        bit                used [256];
        int unsigned       n;
        int unsigned       k;
        int unsigned       a;
        int unsigned       b;
        int unsigned       pick;
        logic [7:0]        c;
        logic [WORD_W-1:0] low_word;
        logic [WORD_W-1:0] high_word;
        logic [WORD_W-1:0] count_word;
        pick = $urandom_range(0, 9);
        n = (pick < 2) ? 2 : (pick < 4) ? 16 : $urandom_range(3, 15);
        for (k = 0; k < 16; k++)
            chars[k] = 8'($urandom);
        for (k = 0; k < n; k++)
        begin
            do
                c = 8'($urandom_range(CH_LOW, CH_HIGH));
            while (used[c] || c == CH_PLUS || c == CH_MINUS);
            used[c]  = 1'b1;
            chars[k] = c;
        end
        // about one setting in five is broken in one way
        if ($urandom_range(0, 99) < 20)
        begin
            a = $urandom_range(0, n - 1);
            case ($urandom_range(0, 4))
                0: n = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
                1:
                begin
                    b = (a + 1 + $urandom_range(0, n - 2)) % n;
                    chars[b] = chars[a];
                end
                2: chars[a] = 8'($urandom_range(0, CH_LOW - 1));
                3: chars[a] = 8'($urandom_range(CH_HIGH + 1, 255));
                default: chars[a] = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
            endcase
        end
        for (k = 0; k < 8; k++)
        begin
            low_word[8*k +: 8]  = chars[k];
            high_word[8*k +: 8] = chars[k+8];
        end
        count_word = {$urandom, $urandom};
        if ($urandom_range(0, 2) != 0)
            count_word[WORD_W-1:COUNT_W] = '0;
        count_word[COUNT_W-1:0] = n[COUNT_W-1:0];
        write_reg(REG_DIGITS_LOW, low_word);
        write_reg(REG_DIGITS_HIGH, high_word);
        if ($urandom_range(0, 99) < 30)
            write_reg(REG_UNUSED, {$urandom, $urandom});
        write_reg(REG_DIGIT_COUNT, count_word);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [DATA_W-1:0] random_value();
        logic [DATA_W-1:0] v;
        longint unsigned   power;
        int unsigned       radix;
        int unsigned       steps;
        int unsigned       pick;
        radix = (alpha_count >= 2 && alpha_count <= 16) ? alpha_count : 10;
        pick  = $urandom_range(0, 5);
        case (pick)
            0: v = $urandom;
            1: v = $urandom_range(0, 40);
            2:
            case ($urandom_range(0, 3))
                0: v = '0;
                1: v = 32'h7FFF_FFFF;
                2: v = 32'h8000_0000;
                default: v = 32'h8000_0001;
            endcase
            3, 4:
            begin
                // around a power of the radix, where the digit count steps
                power = 1;
                steps = $urandom_range(1, 31);
                while (steps != 0 && power * radix <= 64'h8000_0000)
                begin
                    power = power * radix;
                    steps--;
                end
                v = power[DATA_W-1:0] - $urandom_range(0, 1);
            end
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        if (pick != 0 && pick != 2 && $urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    always @(posedge clk)
    begin : check_chars
        text_char_t want;
        if (rst_n && strobe)
        begin
            if (pending_chars.size() == 0)
                report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                          character, last));
            else
            begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (character !== want.character)
                    report_mismatch($sformatf("character 0x%02h, wanted 0x%02h",
                                              character, want.character));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0b, wanted %0b on character 0x%02h",
                                              last, want.last, want.character));
            end
        end
    end

    initial
    begin
        int unsigned phase;
        int unsigned items;
        int unsigned valid_items;
        int unsigned idle_pct;
        bit          sent_since_write;

        phase            = 0;
        valid_items      = 0;
        sent_since_write = 1'b0;

        // after reset the count is zero, so nothing comes out
        stim_rows.push_back(typed_row(32'd5, ""));
        stim_rows.push_back(cfg_row(REG_DIGITS_LOW, HEX_LOW));
        stim_rows.push_back(cfg_row(REG_DIGITS_HIGH, HEX_HIGH));
        stim_rows.push_back(cfg_row(REG_DIGIT_COUNT, 64'd16));
        stim_rows.push_back(typed_row(32'd0, "0"));
        stim_rows.push_back(typed_row(32'h7FFF_FFFF, "7FFFFFFF"));
        stim_rows.push_back(typed_row(32'h8000_0000, "-80000000"));
        stim_rows.push_back(typed_row(32'hFFFF_FFFF, "-1"));
        stim_rows.push_back(typed_row(32'd255, "FF"));
        stim_rows.push_back(cfg_row(REG_DIGIT_COUNT, 64'd10));
        stim_rows.push_back(typed_row(32'h8000_0000, "-2147483648"));
        stim_rows.push_back(typed_row(32'h7FFF_FFFF, "2147483647"));
        stim_rows.push_back(cfg_row(REG_UNUSED, 64'd3));
        stim_rows.push_back(typed_row(32'd100, "100"));
        // binary: the most negative value gives the longest text
        stim_rows.push_back(cfg_row(REG_DIGIT_COUNT, 64'd2));
        stim_rows.push_back(predicted_row(32'h8000_0000));
        stim_rows.push_back(predicted_row(32'h7FFF_FFFF));
        stim_rows.push_back(typed_row(32'hFFFF_FFFF, "-1"));
        stim_rows.push_back(typed_row(32'd5, "101"));
        // count out of range
        stim_rows.push_back(cfg_row(REG_DIGIT_COUNT, 64'd17));
        stim_rows.push_back(typed_row(32'd1, ""));
        stim_rows.push_back(cfg_row(REG_DIGIT_COUNT, 64'd31));
        stim_rows.push_back(typed_row(32'd1, ""));
        stim_rows.push_back(cfg_row(REG_DIGIT_COUNT, 64'd1));
        stim_rows.push_back(typed_row(32'd0, ""));
        // edge characters, unused bytes left at zero
        stim_rows.push_back(cfg_row(REG_DIGITS_LOW, 64'h7E21));
        stim_rows.push_back(cfg_row(REG_DIGIT_COUNT, 64'd2));
        stim_rows.push_back(typed_row(32'hFFFF_FFFE, "-~!"));
        stim_rows.push_back(cfg_row(REG_DIGITS_LOW, 64'h2B21));
        stim_rows.push_back(typed_row(32'd1, ""));
        stim_rows.push_back(cfg_row(REG_DIGITS_LOW, 64'h2D21));
        stim_rows.push_back(typed_row(32'd1, ""));
        stim_rows.push_back(cfg_row(REG_DIGITS_LOW, 64'h2021));
        stim_rows.push_back(typed_row(32'd1, ""));
        stim_rows.push_back(cfg_row(REG_DIGITS_LOW, 64'h7F21));
        stim_rows.push_back(typed_row(32'd1, ""));
        stim_rows.push_back(cfg_row(REG_DIGITS_LOW, 64'h2121));
        stim_rows.push_back(typed_row(32'd1, ""));
        // bad last character counts only while it is in use
        stim_rows.push_back(cfg_row(REG_DIGITS_LOW, HEX_LOW));
        stim_rows.push_back(cfg_row(REG_DIGITS_HIGH, 64'h2D45_4443_4241_3938));
        stim_rows.push_back(cfg_row(REG_DIGIT_COUNT, 64'd16));
        stim_rows.push_back(typed_row(32'd1, ""));
        stim_rows.push_back(cfg_row(REG_DIGIT_COUNT, 64'd15));
        stim_rows.push_back(predicted_row(32'h7FFF_FFFF));
        stim_rows.push_back(cfg_row(REG_DIGITS_LOW, 64'hFFFF_FFFF_FF7E_5A21));
        stim_rows.push_back(cfg_row(REG_DIGIT_COUNT, 64'd3));
        stim_rows.push_back(predicted_row(32'hFFFF_FFF9));

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[r])
        begin
            if (stim_rows[r].is_write)
            begin
                if (sent_since_write)
                    drain_block();
                sent_since_write = 1'b0;
                write_reg(stim_rows[r].index, stim_rows[r].data);
            end
            else
            begin
                cfg_write <= 1'b0;
                send_value(stim_rows[r].operand, stim_rows[r].typed, stim_rows[r].text);
                sent_since_write = 1'b1;
            end
        end

        while (valid_items < RANDOM_ITEMS)
        begin
            drain_block();
            pick_alphabet();
            idle_pct = IDLE_PCT[phase % 4];
            items = alphabet_valid() ? $urandom_range(8, 30) : $urandom_range(2, 5);
            repeat (items)
            begin
                sender_gap(idle_pct);
                send_value(random_value(), 1'b0, "");
                if (alphabet_valid())
                    valid_items++;
            end
            phase++;
        end
        drain_block();

        $display("tb_top: %0d values converted, %0d under an invalid alphabet, %0d characters checked",
                 values_sent, silent_values, chars_checked);
        $display("tb_top: %0d random alphabet settings, %0d distinct radixes",
                 settings_used, $countones(radix_seen));
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
